>>> rtl/stmf_pkg.sv
// stmf_pkg: window size, derived widths, controller/datapath bundles and slot arithmetic
// shared by every module of the sliding trimmed median filter; no dependencies
`default_nettype none

package stmf_pkg;

  localparam int WINDOW     = 10;
  localparam int HIST_DEPTH = 2 * WINDOW;
  localparam int SAMPLE_W   = 16;
  localparam int MED_W      = 17;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int SEEN_W     = $clog2(HIST_DEPTH + 1);
  localparam int LANE_W     = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  // sorted positions of the two middle survivors after trimming one max and one min
  localparam int RANK_LO    = (WINDOW - 1) / 2;
  localparam int RANK_HI    = WINDOW / 2;

  typedef struct packed {
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                rank_en;
    logic [LANE_W-1:0]   cand;
    logic                out_load;
    logic                out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W:0] s);
    logic [SLOT_W:0] r;
    r = (s >= (SLOT_W + 1)'(HIST_DEPTH)) ? s - (SLOT_W + 1)'(HIST_DEPTH) : s;
    return r[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return slot_wrap({1'b0, s} + (SLOT_W + 1)'(1));
  endfunction

endpackage

`default_nettype wire

>>> rtl/stmf_ctrl.sv
// stmf_ctrl: sequencer for track counting, history slots and per-window load/rank/emit
// depends on stmf_pkg
`default_nettype none

module stmf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             end_of_track_i,
  input  stmf_pkg::status_t status_i,
  output stmf_pkg::cmd_t    cmd_o
);
  import stmf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RANK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [SLOT_W-1:0] wslot_q, wslot_d;
  logic [SLOT_W-1:0] win_slot_q, win_slot_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [LANE_W-1:0] win_q, win_d;
  logic [CNT_W-1:0]  step_q, step_d;

  logic              accept;
  logic              was_full;
  logic              reach_full;
  logic [SLOT_W-1:0] base;
  logic [SLOT_W-1:0] steady_start;
  logic              win_last;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign accept       = in_valid_i & in_ready_o;
  assign was_full     = (seen_q == SEEN_W'(HIST_DEPTH));
  assign reach_full   = (seen_q == SEEN_W'(HIST_DEPTH - 1));
  assign base         = slot_inc(wslot_q);
  assign steady_start = slot_wrap({1'b0, base} + (SLOT_W + 1)'(WINDOW - 1));
  assign win_last     = (win_q == LANE_W'(WINDOW - 1));

  always_comb begin
    state_d    = state_q;
    seen_d     = seen_q;
    wslot_d    = wslot_q;
    win_slot_d = win_slot_q;
    rd_slot_d  = rd_slot_q;
    win_d      = win_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.wr_addr  = wslot_q;
    cmd_o.rd_addr  = rd_slot_q;
    cmd_o.cand     = step_q[LANE_W-1:0];
    cmd_o.out_last = win_last;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.wr_en = 1'b1;
          step_d      = '0;
          if (!was_full) seen_d = seen_q + SEEN_W'(1);
          wslot_d = base;
          if (was_full) begin
            win_d      = LANE_W'(WINDOW - 1);
            win_slot_d = steady_start;
            rd_slot_d  = steady_start;
            state_d    = ST_LOAD;
          end else if (reach_full) begin
            win_d      = '0;
            win_slot_d = base;
            rd_slot_d  = base;
            state_d    = ST_LOAD;
          end
          if (end_of_track_i) begin
            seen_d  = '0;
            wslot_d = '0;
          end
        end
      end
      ST_LOAD: begin
        if (step_q == CNT_W'(WINDOW)) begin
          step_d  = '0;
          state_d = ST_RANK;
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_slot_d   = slot_inc(rd_slot_q);
          step_d      = step_q + CNT_W'(1);
        end
      end
      ST_RANK: begin
        cmd_o.rank_en = 1'b1;
        if (step_q == CNT_W'(WINDOW - 1)) begin
          step_d  = '0;
          state_d = ST_EMIT;
        end else begin
          step_d = step_q + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (win_last) begin
            state_d = ST_IDLE;
          end else begin
            win_d      = win_q + LANE_W'(1);
            win_slot_d = slot_inc(win_slot_q);
            rd_slot_d  = slot_inc(win_slot_q);
            state_d    = ST_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      seen_q     <= '0;
      wslot_q    <= '0;
      win_slot_q <= '0;
      rd_slot_q  <= '0;
      win_q      <= '0;
      step_q     <= '0;
    end else begin
      state_q    <= state_d;
      seen_q     <= seen_d;
      wslot_q    <= wslot_d;
      win_slot_q <= win_slot_d;
      rd_slot_q  <= rd_slot_d;
      win_q      <= win_d;
      step_q     <= step_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stmf_dp.sv
// stmf_dp: sample history memory, window lane registers, rank unit and output register
// depends on stmf_pkg
`default_nettype none

module stmf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [stmf_pkg::SAMPLE_W-1:0] sample_i,
  input  stmf_pkg::cmd_t                cmd_i,
  output stmf_pkg::status_t             status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [stmf_pkg::MED_W-1:0]    median_doubled_o,
  output logic                          last_in_burst_o
);
  import stmf_pkg::*;

  logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_vld_q;
  logic [SAMPLE_W-1:0] lanes_q [WINDOW];
  logic [SAMPLE_W-1:0] lo_q, hi_q;
  logic [SAMPLE_W-1:0] cand_val;
  logic [CNT_W-1:0]    rank;
  logic                out_valid_q;
  logic [MED_W-1:0]    median_q;
  logic                last_q;

  // history memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) hist_mem[cmd_i.wr_addr] <= sample_i;
    if (cmd_i.rd_en) rd_data_q <= hist_mem[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      lanes_q[0] <= rd_data_q;
      for (int i = 1; i < WINDOW; i++) lanes_q[i] <= lanes_q[i-1];
    end
  end

  // stable rank of the candidate lane among all lanes
  assign cand_val = lanes_q[cmd_i.cand];

  always_comb begin
    rank = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if ((lanes_q[i] < cand_val) ||
          ((lanes_q[i] == cand_val) && (LANE_W'(i) < cmd_i.cand))) begin
        rank = rank + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rank_en && (rank == CNT_W'(RANK_LO))) lo_q <= cand_val;
    if (cmd_i.rank_en && (rank == CNT_W'(RANK_HI))) hi_q <= cand_val;
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      median_q <= {1'b0, lo_q} + {1'b0, hi_q};
      last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = median_q;
  assign last_in_burst_o  = last_q;

endmodule

`default_nettype wire

>>> rtl/sliding_trimmed_median_filter.sv
// sliding_trimmed_median_filter: top level joining the sequencer and the datapath
// depends on stmf_pkg, stmf_ctrl, stmf_dp
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o  sample_i, end_of_track_i
//   out      output     out_valid_o / out_ready_i median_doubled_o, last_in_burst_o
//
// a word that causes no result is taken without leaving the idle state; each result takes
// WINDOW reads through the single history read port, a read-latency step, WINDOW rank
// steps of one candidate each, and a load of the output register once it is free
// in_ready_o is low throughout a burst of WINDOW results
// asynchronous active-low reset clears counters and slots; history contents are not reset
// a stalled output holds the sequencer in its emit step; the last result of a burst
// waits in the output register while the next input word is already taken
`default_nettype none

module sliding_trimmed_median_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [stmf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          end_of_track_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [stmf_pkg::MED_W-1:0]    median_doubled_o,
  output logic                          last_in_burst_o
);
  import stmf_pkg::*;

  // commands from the sequencer, output-register status back
  cmd_t    cmd;
  status_t status;

  // sequencer: track count, write slot, window start and per-window step counter
  stmf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .end_of_track_i (end_of_track_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  // datapath: history memory, window lanes, rank selection, output register
  stmf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_i         (sample_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .median_doubled_o (median_doubled_o),
    .last_in_burst_o  (last_in_burst_o)
  );

endmodule

`default_nettype wire

>>> rtl/stmf_checker.sv
// stmf_checker: port-level assertions for the sliding trimmed median filter
// depends on stmf_pkg; bound to sliding_trimmed_median_filter at the end of this file
`default_nettype none

module stmf_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [stmf_pkg::MED_W-1:0]    median_doubled_o,
  input  logic                          last_in_burst_o
);
  import stmf_pkg::*;

  logic out_fire;
  logic in_fire;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_fire  = in_valid_i && in_ready_o;

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(median_doubled_o) && $stable(last_in_burst_o))
    else $error("result payload changed while stalled");

  // a new result only appears while the input side is busy computing
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a window computation");

  // taking an input word never loads a result in the same cycle
  a_no_rise_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !$rose(out_valid_o))
    else $error("result loaded while an input word was taken");

  // while a result that is not a burst's last is taken, the input side is not ready
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && in_ready_o && !last_in_burst_o |-> 1'b0)
    else $error("input ready while a burst is unfinished");

endmodule

bind sliding_trimmed_median_filter stmf_checker u_stmf_checker (.*);

`default_nettype wire
